>>> hw/rtl/twd_pkg.sv
// ----------------------------------------------------------------------------
// twd_pkg: shared types and constants of the trie word dictionary
// Transaction payloads, function and status codes, memory control bundle
// and controller states.
// ----------------------------------------------------------------------------
package twd_pkg;

  localparam int unsigned NodesDefault    = 1024;
  localparam int unsigned AlphabetDefault = 26;
  localparam logic [7:0]  LetterBase      = 8'd97;  // 'a'

  localparam logic [1:0] FnInsert = 2'd0;
  localparam logic [1:0] FnSearch = 2'd1;
  localparam logic [1:0] FnPrefix = 2'd2;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StFull    = 2'd1,
    StBadChar = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] char_code;
    logic       no_char;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic    found;
    status_e status;
  } out_item_t;

  typedef struct packed {
    logic row_re;
    logic row_we;
    logic mark_re;
    logic mark_we;
  } mem_ctl_t;

  typedef enum logic [2:0] {
    SClear,
    SIdle,
    SLook,
    SFin,
    SMark
  } state_e;

endpackage

>>> hw/rtl/twd_mem.sv
// ----------------------------------------------------------------------------
// twd_mem: node storage
// Child row memory (one row of child indices per node) and word end mark
// memory. Synchronous, with a registered read.
// ----------------------------------------------------------------------------
module twd_mem #(
  parameter int unsigned NODES    = twd_pkg::NodesDefault,
  parameter int unsigned ALPHABET = twd_pkg::AlphabetDefault,
  localparam int unsigned NW      = (NODES > 1) ? $clog2(NODES) : 1,
  localparam int unsigned RW      = ALPHABET * NW
) (
  input  logic              clk_i,
  input  twd_pkg::mem_ctl_t ctl_i,
  input  logic [NW-1:0]     row_addr_i,
  input  logic [RW-1:0]     row_wdata_i,
  output logic [RW-1:0]     row_rdata_o,
  input  logic [NW-1:0]     mark_addr_i,
  input  logic              mark_wdata_i,
  output logic              mark_rdata_o
);
  import twd_pkg::*;

  logic [RW-1:0] row_mem [NODES];
  logic          mark_mem [NODES];
  logic [RW-1:0] row_rdata_q;
  logic          mark_rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.row_we) begin
      row_mem[row_addr_i] <= row_wdata_i;
    end
    if (ctl_i.row_re) begin
      row_rdata_q <= row_mem[row_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.mark_we) begin
      mark_mem[mark_addr_i] <= mark_wdata_i;
    end
    if (ctl_i.mark_re) begin
      mark_rdata_q <= mark_mem[mark_addr_i];
    end
  end

  assign row_rdata_o  = row_rdata_q;
  assign mark_rdata_o = mark_rdata_q;

endmodule

>>> hw/rtl/twd_ctrl.sv
// ----------------------------------------------------------------------------
// twd_ctrl: trie walk controller
// Clears the node memories after reset, walks one character per transaction
// with a read-modify-write of the current node's child row, allocates nodes
// from a bump counter and produces the per-word result.
// ----------------------------------------------------------------------------
module twd_ctrl #(
  parameter int unsigned NODES    = twd_pkg::NodesDefault,
  parameter int unsigned ALPHABET = twd_pkg::AlphabetDefault,
  localparam int unsigned NW      = (NODES > 1) ? $clog2(NODES) : 1,
  localparam int unsigned NFW     = NW + 1,
  localparam int unsigned LW      = (ALPHABET > 1) ? $clog2(ALPHABET) : 1,
  localparam int unsigned RW      = ALPHABET * NW
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  twd_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output twd_pkg::out_item_t out_data_o,
  output twd_pkg::mem_ctl_t  mem_ctl_o,
  output logic [NW-1:0]      row_addr_o,
  output logic [RW-1:0]      row_wdata_o,
  input  logic [RW-1:0]      row_rdata_i,
  output logic [NW-1:0]      mark_addr_o,
  output logic               mark_wdata_o,
  input  logic               mark_rdata_i
);
  import twd_pkg::*;

  state_e          state_q, state_d;
  logic [1:0]      func_q, func_d;
  logic            last_q, last_d;
  logic [LW-1:0]   letter_q, letter_d;
  logic [NW-1:0]   cur_q, cur_d;
  logic [NFW-1:0]  nfree_q, nfree_d;
  logic            broken_q, broken_d;
  status_e         err_q, err_d;
  logic [NW-1:0]   clr_q, clr_d;
  logic            out_valid_q, out_valid_d;
  out_item_t       out_q, out_d;

  logic [ALPHABET-1:0][NW-1:0] row_view;
  logic [ALPHABET-1:0][NW-1:0] row_new;
  logic [NW-1:0]   child;
  logic [7:0]      code_diff;
  logic            code_ok;
  logic            active;
  logic            accept;
  logic            word_ok;

  assign row_view  = row_rdata_i;
  assign child     = row_view[letter_q];
  assign code_diff = in_data_i.char_code - LetterBase;
  assign code_ok   = (in_data_i.char_code >= LetterBase) &&
                     ({1'b0, in_data_i.char_code} < (9'(LetterBase) + 9'(ALPHABET)));
  assign active    = !in_data_i.no_char && (err_q == StOk) && !broken_q;
  assign accept    = in_valid_i && in_ready_o;
  assign word_ok   = (err_q == StOk) && !broken_q;

  always_comb begin
    row_new           = row_view;
    row_new[letter_q] = nfree_q[NW-1:0];
  end

  always_comb begin
    state_d     = state_q;
    func_d      = func_q;
    last_d      = last_q;
    letter_d    = letter_q;
    cur_d       = cur_q;
    nfree_d     = nfree_q;
    broken_d    = broken_q;
    err_d       = err_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    in_ready_o  = 1'b0;
    mem_ctl_o   = '0;
    row_addr_o  = cur_q;
    row_wdata_o = row_new;
    mark_addr_o = cur_q;
    mark_wdata_o = 1'b1;

    case (state_q)
      SClear: begin
        mem_ctl_o.row_we  = 1'b1;
        mem_ctl_o.mark_we = 1'b1;
        row_addr_o        = clr_q;
        row_wdata_o       = '0;
        mark_addr_o       = clr_q;
        mark_wdata_o      = 1'b0;
        clr_d             = clr_q + 1'b1;
        if (clr_q == NW'(NODES - 1)) begin
          state_d = SIdle;
        end
      end
      SIdle: begin
        in_ready_o = !out_valid_q || out_ready_i;
        if (accept) begin
          func_d   = in_data_i.func;
          last_d   = in_data_i.last;
          letter_d = code_diff[LW-1:0];
          if (active && code_ok) begin
            mem_ctl_o.row_re = 1'b1;
            state_d          = SLook;
          end else begin
            if (active) begin
              err_d = StBadChar;
            end
            state_d = in_data_i.last ? SFin : SIdle;
          end
        end
      end
      SLook: begin
        if (child != '0) begin
          cur_d = child;
        end else if (func_q != FnInsert) begin
          broken_d = 1'b1;
        end else if (nfree_q >= NFW'(NODES)) begin
          err_d = StFull;
        end else begin
          // new node: link it into the current row
          mem_ctl_o.row_we = 1'b1;
          cur_d            = nfree_q[NW-1:0];
          nfree_d          = nfree_q + 1'b1;
        end
        state_d = last_q ? SFin : SIdle;
      end
      SFin: begin
        if (word_ok && func_q == FnSearch) begin
          mem_ctl_o.mark_re = 1'b1;
          state_d           = SMark;
        end else begin
          if (word_ok && func_q == FnInsert) begin
            mem_ctl_o.mark_we = 1'b1;
          end
          out_d.found  = word_ok && (func_q != FnInsert);
          out_d.status = err_q;
          out_valid_d  = 1'b1;
          cur_d        = '0;
          broken_d     = 1'b0;
          err_d        = StOk;
          state_d      = SIdle;
        end
      end
      SMark: begin
        out_d.found  = mark_rdata_i;
        out_d.status = StOk;
        out_valid_d  = 1'b1;
        cur_d        = '0;
        broken_d     = 1'b0;
        err_d        = StOk;
        state_d      = SIdle;
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SClear;
      func_q      <= FnInsert;
      last_q      <= 1'b0;
      cur_q       <= '0;
      nfree_q     <= NFW'(1);
      broken_q    <= 1'b0;
      err_q       <= StOk;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      func_q      <= func_d;
      last_q      <= last_d;
      cur_q       <= cur_d;
      nfree_q     <= nfree_d;
      broken_q    <= broken_d;
      err_q       <= err_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    letter_q <= letter_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> hw/rtl/trie_word_dictionary_core.sv
// ----------------------------------------------------------------------------
// trie_word_dictionary_core: trie based word dictionary
// Inserts, looks up and prefix-matches words streamed one character per
// transaction against a fixed-size node table.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_data_i): one character per
//   transaction with func, char_code, no_char and last. The transaction with
//   last set closes the word and produces exactly one output transaction.
//   Output channel (out_valid_o / out_ready_i / out_data_o): found and status.
//   Throughput: a character that walks the trie also passes through SLook, as the
//   synchronous read of the current node's child row must finish before the next
//   character can address the memory. Items that do not walk are taken in SIdle.
//   The closing item adds state SFin (insert, prefix, errors) or SFin and SMark
//   (exact search, which reads the word end mark memory).
//   out_valid_o is registered and is raised from SFin or SMark.
//   Reset: both node memories are cleared, one node per cycle; in_ready_o
//   stays low until that is done.
//   Stall: the result sits in an output register; a new item is taken while
//   a result waits only if that result is taken in the same cycle.
// ----------------------------------------------------------------------------
module trie_word_dictionary_core #(
  parameter int unsigned NODES    = twd_pkg::NodesDefault,
  parameter int unsigned ALPHABET = twd_pkg::AlphabetDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  twd_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output twd_pkg::out_item_t out_data_o
);
  import twd_pkg::*;

  localparam int unsigned NW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int unsigned RW = ALPHABET * NW;

  mem_ctl_t      mem_ctl;
  logic [NW-1:0] row_addr;
  logic [RW-1:0] row_wdata;
  logic [RW-1:0] row_rdata;
  logic [NW-1:0] mark_addr;
  logic          mark_wdata;
  logic          mark_rdata;

  twd_ctrl #(
    .NODES    (NODES),
    .ALPHABET (ALPHABET)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o),
    .mem_ctl_o    (mem_ctl),
    .row_addr_o   (row_addr),
    .row_wdata_o  (row_wdata),
    .row_rdata_i  (row_rdata),
    .mark_addr_o  (mark_addr),
    .mark_wdata_o (mark_wdata),
    .mark_rdata_i (mark_rdata)
  );

  twd_mem #(
    .NODES    (NODES),
    .ALPHABET (ALPHABET)
  ) u_mem (
    .clk_i        (clk_i),
    .ctl_i        (mem_ctl),
    .row_addr_i   (row_addr),
    .row_wdata_i  (row_wdata),
    .row_rdata_o  (row_rdata),
    .mark_addr_i  (mark_addr),
    .mark_wdata_i (mark_wdata),
    .mark_rdata_o (mark_rdata)
  );

endmodule

>>> hw/rtl/twd_checker.sv
// ----------------------------------------------------------------------------
// twd_checker: port-level checks of the trie word dictionary
// Observes the top level's channels and flags result and handshake slips.
// ----------------------------------------------------------------------------
module twd_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input twd_pkg::in_item_t  in_data_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input twd_pkg::out_item_t out_data_o
);
  import twd_pkg::*;

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed or dropped while stalled");

  // an error result never reports a hit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != StOk) |-> !out_data_o.found)
    else $error("found set together with an error status");

  // only the three defined status codes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.status == StOk) || (out_data_o.status == StFull) ||
                    (out_data_o.status == StBadChar))
    else $error("undefined status code");

  // a character that does not close the word raises no result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !in_data_i.last && !out_valid_o |=> !out_valid_o)
    else $error("result raised by a non-final transaction");

endmodule

bind trie_word_dictionary_core twd_checker u_twd_checker (.*);

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench of trie_word_dictionary_core
// Streams words one character per transaction and predicts each answer with a
// trie kept in the testbench. Directed cases cover the root, the alphabet edges,
// bad characters, broken paths and mixed functions. Random words follow, then a
// pool fill and words against the full pool. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import twd_pkg::*;

  localparam int unsigned NODES      = twd_pkg::NodesDefault;
  localparam int unsigned ALPHA      = twd_pkg::AlphabetDefault;
  localparam int          NodeW      = $clog2(NODES);
  localparam int          WordMax    = 24;
  localparam int          SavedMax   = 64;
  localparam int          CycleLimit = 200000;
  localparam logic [1:0]  FnAltPrefix = 2'd3;  // decodes as a prefix search

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // stimulus and expectations
  in_item_t  char_q[$];
  out_item_t answer_q[$];
  int        queued_cnt = 0;
  int        errors = 0;
  int        send_idle_pct = 10;
  int        recv_idle_pct = 48;
  int        hold_cnt = 0;
  int        cycle_cnt = 0;

  // trie image
  bit [NodeW-1:0] kid_tbl [NODES*ALPHA];
  bit             end_mark [NODES];
  int unsigned    free_node = 1;
  int unsigned    walk_node = 0;
  bit             walk_broken = 1'b0;
  status_e        walk_err = StOk;

  // word scratch and a store of inserted words for reuse
  logic [7:0] wbuf [WordMax];
  int         wlen;
  logic [7:0] saved_chr [SavedMax][WordMax];
  int         saved_len [SavedMax];
  int         saved_cnt = 0;

  trie_word_dictionary_core #(
    .NODES   (NODES),
    .ALPHABET(ALPHA)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  task automatic trie_feed_char(input logic [1:0] fn, input logic [7:0] code);
    int unsigned slot;
    int unsigned kid;
    if (walk_err != StOk || walk_broken) return;
    if (code < LetterBase || code >= LetterBase + ALPHA) begin
      walk_err = StBadChar;
      return;
    end
    slot = walk_node * ALPHA + (code - LetterBase);
    kid  = kid_tbl[slot];
    if (kid == 0) begin
      if (fn != FnInsert) begin
        walk_broken = 1'b1;
        return;
      end
      if (free_node >= NODES) begin
        walk_err = StFull;
        return;
      end
      kid = free_node;
      free_node++;
      kid_tbl[slot] = NodeW'(kid);
      end_mark[kid] = 1'b0;
    end
    walk_node = kid;
  endtask

  task automatic trie_accept_item(input in_item_t it);
    out_item_t ans;
    if (!it.no_char) trie_feed_char(it.func, it.char_code);
    if (it.last) begin
      ans.found  = 1'b0;
      ans.status = walk_err;
      if (walk_err == StOk && !walk_broken) begin
        if (it.func == FnInsert) end_mark[walk_node] = 1'b1;
        else if (it.func == FnSearch) ans.found = end_mark[walk_node];
        else ans.found = 1'b1;
      end
      answer_q.push_back(ans);
      walk_node   = 0;
      walk_broken = 1'b0;
      walk_err    = StOk;
    end
  endtask

  task automatic check_answer(input out_item_t got);
    out_item_t want;
    if (answer_q.size() == 0) begin
      $display("%0t: result: expected none actual found %0b status %0d", $time,
               got.found, got.status);
      errors++;
    end else begin
      want = answer_q.pop_front();
      if (got.found !== want.found) begin
        $display("%0t: found: expected %0b actual %0b", $time, want.found, got.found);
        errors++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status: expected %0d actual %0d", $time, want.status,
                 got.status);
        errors++;
      end
    end
  endtask

  // sender: prediction runs on every accepted transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready) trie_accept_item(in_data);
      if (!in_valid || in_ready) begin
        if (char_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= char_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls plus one long hold-off
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && out_ready) check_answer(out_data);
      if (hold_cnt > 0) begin
        hold_cnt  <= hold_cnt - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic push_item(input logic [1:0] fn, input logic [7:0] code,
                           input logic nc, input logic lst);
    in_item_t it;
    it.func      = fn;
    it.char_code = code;
    it.no_char   = nc;
    it.last      = lst;
    char_q.push_back(it);
    queued_cnt++;
  endtask

  // sprinkles empty items and func changes into the word
  task automatic queue_word(input logic [1:0] fn, input bit empty_tail);
    logic [1:0] f;
    for (int i = 0; i < wlen; i++) begin
      if ($urandom_range(99) < 5) push_item(fn, 8'($urandom), 1'b1, 1'b0);
      f = ($urandom_range(99) < 8) ? 2'($urandom_range(3)) : fn;
      push_item(f, wbuf[i], 1'b0, (i == wlen - 1) && !empty_tail);
    end
    if (wlen == 0 || empty_tail) push_item(fn, 8'($urandom), 1'b1, 1'b1);
  endtask

  task automatic make_random_word();
    int pick;
    int span;
    if (saved_cnt > 0 && $urandom_range(99) < 40) begin
      pick = $urandom_range(saved_cnt - 1);
      wlen = saved_len[pick];
      for (int i = 0; i < wlen; i++) wbuf[i] = saved_chr[pick][i];
      if ($urandom_range(99) < 30) begin
        wlen = $urandom_range(wlen);
      end else if ($urandom_range(99) < 15 && wlen < WordMax) begin
        wbuf[wlen] = 8'(LetterBase + $urandom_range(ALPHA - 1));
        wlen++;
      end
    end else begin
      if ($urandom_range(99) < 3) wlen = 0;
      else if ($urandom_range(99) < 5) wlen = $urandom_range(WordMax);
      else wlen = $urandom_range(8, 1);
      // narrow letter set makes shared prefixes and hits likely
      span = ($urandom_range(99) < 60) ? 4 : ALPHA;
      for (int i = 0; i < wlen; i++) wbuf[i] = 8'(LetterBase + $urandom_range(span - 1));
    end
    if (wlen > 0 && $urandom_range(99) < 4) wbuf[$urandom_range(wlen - 1)] = 8'($urandom);
  endtask

  task automatic save_word();
    int slot;
    if (wlen == 0) return;
    if (saved_cnt < SavedMax) begin
      slot = saved_cnt;
      saved_cnt++;
    end else begin
      slot = $urandom_range(SavedMax - 1);
    end
    saved_len[slot] = wlen;
    for (int i = 0; i < wlen; i++) saved_chr[slot][i] = wbuf[i];
  endtask

  task automatic random_words(input int n);
    int         stop;
    int         r;
    logic [1:0] fn;
    stop = queued_cnt + n;
    while (queued_cnt < stop) begin
      make_random_word();
      r = $urandom_range(99);
      fn = (r < 40) ? FnInsert : (r < 65) ? FnSearch : (r < 90) ? FnPrefix : FnAltPrefix;
      if (fn == FnInsert) save_word();
      queue_word(fn, $urandom_range(99) < 20);
    end
  endtask

  // plain inserts so nearly every character takes a node
  task automatic fill_word();
    wlen = WordMax;
    for (int i = 0; i < wlen; i++) wbuf[i] = 8'(LetterBase + $urandom_range(ALPHA - 1));
    for (int i = 0; i < wlen; i++) push_item(FnInsert, wbuf[i], 1'b0, i == wlen - 1);
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (char_q.size() != 0 || in_valid || answer_q.size() != 0);
  endtask

  initial begin
    // zero-length words at the root
    push_item(FnInsert, 8'h00, 1'b1, 1'b1);
    push_item(FnSearch, 8'hff, 1'b1, 1'b1);
    push_item(FnPrefix, 8'h00, 1'b1, 1'b1);
    push_item(FnAltPrefix, 8'h00, 1'b1, 1'b1);
    // both ends of the alphabet
    push_item(FnInsert, "a", 1'b0, 1'b0);
    push_item(FnInsert, "z", 1'b0, 1'b1);
    push_item(FnSearch, "a", 1'b0, 1'b0);
    push_item(FnSearch, "z", 1'b0, 1'b1);
    push_item(FnSearch, "a", 1'b0, 1'b1);
    push_item(FnPrefix, "a", 1'b0, 1'b1);
    // bytes just outside the alphabet; the first error sticks
    push_item(FnInsert, 8'd96, 1'b0, 1'b0);
    push_item(FnInsert, "b", 1'b0, 1'b1);
    push_item(FnSearch, 8'd123, 1'b0, 1'b1);
    push_item(FnPrefix, 8'hff, 1'b0, 1'b0);
    push_item(FnPrefix, 8'h00, 1'b0, 1'b1);
    // empty item inside a word
    push_item(FnSearch, "a", 1'b0, 1'b0);
    push_item(FnSearch, 8'h55, 1'b1, 1'b0);
    push_item(FnSearch, "z", 1'b0, 1'b1);
    // broken path, closed by an insert that must not mark
    push_item(FnSearch, "q", 1'b0, 1'b0);
    push_item(FnInsert, "b", 1'b0, 1'b1);
    // mixed functions within one word
    push_item(FnInsert, "m", 1'b0, 1'b0);
    push_item(FnSearch, "n", 1'b0, 1'b1);
    push_item(FnPrefix, "m", 1'b0, 1'b0);
    push_item(FnInsert, "n", 1'b0, 1'b1);
    push_item(FnSearch, "m", 1'b0, 1'b0);
    push_item(FnSearch, "n", 1'b0, 1'b1);
    random_words(50);

    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    while (char_q.size() != 0) @(negedge clk_i);
    send_idle_pct = 48;
    recv_idle_pct = 10;
    random_words(50);
    hold_cnt = 300;  // long output stall so the input backs up
    while (char_q.size() != 0) @(negedge clk_i);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    wait_drained();
    // use up the node pool, one word at a time
    while (free_node < NODES) begin
      fill_word();
      wait_drained();
    end
    fill_word();
    random_words(40);
    wait_drained();

    repeat (20) @(negedge clk_i);
    if (errors == 0) begin
      $display("trie_word_dictionary_core: match");
    end else begin
      $display("trie_word_dictionary_core: mismatch");
    end
    $finish;
  end

  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("trie_word_dictionary_core: mismatch");
    $finish;
  end

endmodule
